### src/rbu_pkg.sv
package rbu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int POS_W     = 12;
  localparam int SCALE_W   = 3;
  localparam int DIM_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_MAX_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W     = ((CNT_MAX_W + 1 > DIM_W) ? CNT_MAX_W + 1 : DIM_W) + 1;
  localparam int PROD_W    = 2 * CH_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NBLK      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_THREE = 3'd3;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd4;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd1024;

  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] left;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    logic             s3;
    logic             lastc;
    logic             lastr;
    logic [NBLK-1:0]  mask;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0] w0;
    logic [CH_W-1:0] w1;
    logic [CH_W-1:0] w2;
    logic [CH_W-1:0] w3;
    logic [3:0]      sh;
  } wt_t;

  typedef struct packed {
    logic [PIX_W-1:0] ul;
    logic [PIX_W-1:0] ur;
    logic [PIX_W-1:0] ll;
    logic [PIX_W-1:0] lr;
    wt_t              wt;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last_run;
    logic             frame_end;
  } gen_t;

  function automatic logic [CH_W-1:0] chan(logic [PIX_W-1:0] p, int k);
    return p[PIX_W-1-CH_W*k -: CH_W];
  endfunction

  function automatic wt_t weights(logic s3, logic [1:0] dy, logic [1:0] dx);
    wt_t w;
    w = '{8'd1, 8'd0, 8'd0, 8'd0, 4'd0};
    if (s3) begin
      case ({dy, dx})
        4'b0000: w = '{8'd1,   8'd0,   8'd0,   8'd0,   4'd0};
        4'b0001: w = '{8'd171, 8'd85,  8'd0,   8'd0,   4'd8};
        4'b0010: w = '{8'd85,  8'd171, 8'd0,   8'd0,   4'd8};
        4'b0100: w = '{8'd171, 8'd0,   8'd85,  8'd0,   4'd8};
        4'b0101: w = '{8'd114, 8'd57,  8'd57,  8'd28,  4'd8};
        4'b0110: w = '{8'd57,  8'd114, 8'd28,  8'd57,  4'd8};
        4'b1000: w = '{8'd85,  8'd0,   8'd171, 8'd0,   4'd8};
        4'b1001: w = '{8'd57,  8'd28,  8'd114, 8'd57,  4'd8};
        4'b1010: w = '{8'd28,  8'd57,  8'd57,  8'd114, 4'd8};
        default: w = '{8'd1,   8'd0,   8'd0,   8'd0,   4'd0};
      endcase
    end else begin
      case ({dy, dx})
        4'b0000: w = '{8'd1, 8'd0, 8'd0, 8'd0, 4'd0};
        4'b0001: w = '{8'd3, 8'd1, 8'd0, 8'd0, 4'd2};
        4'b0010: w = '{8'd1, 8'd1, 8'd0, 8'd0, 4'd1};
        4'b0011: w = '{8'd1, 8'd3, 8'd0, 8'd0, 4'd2};
        4'b0100: w = '{8'd3, 8'd0, 8'd1, 8'd0, 4'd2};
        4'b0101: w = '{8'd9, 8'd3, 8'd3, 8'd1, 4'd4};
        4'b0110: w = '{8'd3, 8'd3, 8'd1, 8'd1, 4'd3};
        4'b0111: w = '{8'd3, 8'd9, 8'd1, 8'd3, 4'd4};
        4'b1000: w = '{8'd1, 8'd0, 8'd1, 8'd0, 4'd1};
        4'b1001: w = '{8'd3, 8'd1, 8'd3, 8'd1, 4'd3};
        4'b1010: w = '{8'd1, 8'd1, 8'd1, 8'd1, 4'd2};
        4'b1011: w = '{8'd1, 8'd3, 8'd1, 8'd3, 4'd3};
        4'b1100: w = '{8'd1, 8'd0, 8'd3, 8'd0, 4'd2};
        4'b1101: w = '{8'd3, 8'd1, 8'd9, 8'd3, 4'd4};
        4'b1110: w = '{8'd1, 8'd1, 8'd3, 8'd3, 4'd3};
        4'b1111: w = '{8'd1, 8'd3, 8'd3, 8'd9, 4'd4};
        default: w = '{8'd1, 8'd0, 8'd0, 8'd0, 4'd0};
      endcase
    end
    return w;
  endfunction

endpackage

### src/rbu_if.sv
interface rbu_pix_if;
  logic                      valid;
  logic                      ready;
  logic [rbu_pkg::CH_W-1:0]  red_in;
  logic [rbu_pkg::CH_W-1:0]  green_in;
  logic [rbu_pkg::CH_W-1:0]  blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rbu_res_if;
  logic                      valid;
  logic                      ready;
  logic [rbu_pkg::CH_W-1:0]  red_out;
  logic [rbu_pkg::CH_W-1:0]  green_out;
  logic [rbu_pkg::CH_W-1:0]  blue_out;
  logic [rbu_pkg::POS_W-1:0] out_col;
  logic [rbu_pkg::POS_W-1:0] out_row;
  logic                      last_of_run;
  logic                      frame_done;

  modport source (output valid, red_out, green_out, blue_out, out_col, out_row,
                  last_of_run, frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_col, out_row,
                  last_of_run, frame_done, output ready);
endinterface

### src/rbu_front.sv
module rbu_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbu_pkg::CFG_W-1:0]       cfg_data_i,
  rbu_pix_if.sink                         pix_i,
  output logic                            a_valid_o,
  output rbu_pkg::item_t                  a_item_o,
  output logic [rbu_pkg::PIX_W-1:0]       above_o,
  input  logic                            a_take_i
);

  logic [rbu_pkg::SCALE_W-1:0] scale_q;
  logic [rbu_pkg::DIM_W-1:0]   width_q;
  logic [rbu_pkg::DIM_W-1:0]   height_q;
  logic [rbu_pkg::COL_W-1:0]   col_q;
  logic [rbu_pkg::ROW_W-1:0]   row_q;
  logic [rbu_pkg::PIX_W-1:0]   left_q;
  logic                        a_valid_q;
  rbu_pkg::item_t              a_item_q;
  logic [rbu_pkg::PIX_W-1:0]   above_q;
  logic [rbu_pkg::PIX_W-1:0]   line_mem [rbu_pkg::MAX_WIDTH];

  logic [rbu_pkg::CMP_W-1:0] w_eff;
  logic [rbu_pkg::CMP_W-1:0] h_eff;
  logic [rbu_pkg::PIX_W-1:0] cur;
  logic                      lastc;
  logic                      lastr;
  logic                      acc;
  rbu_pkg::item_t            item_d;

  always_comb begin
    if (width_q == '0) begin
      w_eff = rbu_pkg::CMP_W'(1);
    end else if (rbu_pkg::CMP_W'(width_q) > rbu_pkg::CMP_W'(rbu_pkg::MAX_WIDTH)) begin
      w_eff = rbu_pkg::CMP_W'(rbu_pkg::MAX_WIDTH);
    end else begin
      w_eff = rbu_pkg::CMP_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = rbu_pkg::CMP_W'(1);
    end else if (rbu_pkg::CMP_W'(height_q) > rbu_pkg::CMP_W'(rbu_pkg::MAX_HEIGHT)) begin
      h_eff = rbu_pkg::CMP_W'(rbu_pkg::MAX_HEIGHT);
    end else begin
      h_eff = rbu_pkg::CMP_W'(height_q);
    end
  end

  assign cur   = {pix_i.red_in, pix_i.green_in, pix_i.blue_in};
  assign lastc = (rbu_pkg::CMP_W'(col_q) + rbu_pkg::CMP_W'(1)) >= w_eff;
  assign lastr = (rbu_pkg::CMP_W'(row_q) + rbu_pkg::CMP_W'(1)) >= h_eff;

  assign pix_i.ready = !a_valid_q || a_take_i;
  assign acc         = pix_i.valid && pix_i.ready;

  always_comb begin
    item_d.cur     = cur;
    item_d.left    = left_q;
    item_d.c       = col_q;
    item_d.r       = row_q;
    item_d.s3      = (scale_q == rbu_pkg::SCALE_THREE);
    item_d.lastc   = lastc;
    item_d.lastr   = lastr;
    item_d.mask[0] = (row_q != '0) && (col_q != '0);
    item_d.mask[1] = (row_q != '0) && lastc;
    item_d.mask[2] = lastr && (col_q != '0);
    item_d.mask[3] = lastr && lastc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= rbu_pkg::SCALE_RESET;
      width_q   <= rbu_pkg::DIM_RESET;
      height_q  <= rbu_pkg::DIM_RESET;
      col_q     <= '0;
      row_q     <= '0;
      left_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbu_pkg::REG_SCALE:  scale_q  <= cfg_data_i[rbu_pkg::SCALE_W-1:0];
          rbu_pkg::REG_WIDTH:  width_q  <= cfg_data_i[rbu_pkg::DIM_W-1:0];
          rbu_pkg::REG_HEIGHT: height_q <= cfg_data_i[rbu_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        left_q <= cur;
        if (lastc) begin
          col_q <= '0;
          row_q <= lastr ? '0 : row_q + rbu_pkg::ROW_W'(1);
        end else begin
          col_q <= col_q + rbu_pkg::COL_W'(1);
        end
      end
      if (acc) begin
        a_valid_q <= 1'b1;
      end else if (a_take_i) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_item_q <= item_d;
    end
  end

  // read-before-write: the read returns the entry from the row above
  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_mem[col_q] <= cur;
      above_q         <= line_mem[col_q];
    end
  end

  assign a_valid_o = a_valid_q;
  assign a_item_o  = a_item_q;
  assign above_o   = above_q;

endmodule

### src/rbu_gen.sv
module rbu_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      a_valid_i,
  input  rbu_pkg::item_t            a_item_i,
  input  logic [rbu_pkg::PIX_W-1:0] above_i,
  output logic                      a_take_o,
  input  logic                      en_i,
  output logic                      gen_valid_o,
  output rbu_pkg::gen_t             gen_o
);

  logic                         w_valid_q;
  rbu_pkg::item_t               w_q;
  logic [rbu_pkg::PIX_W-1:0]    w_above_q;
  logic [rbu_pkg::PIX_W-1:0]    w_ul_q;
  logic [rbu_pkg::PIX_W-1:0]    ul_q;
  logic [rbu_pkg::NBLK-1:0]     rem_q;
  logic [1:0]                   dx_q;
  logic [1:0]                   dy_q;

  logic [rbu_pkg::NBLK-1:0]     blk_oh;
  logic [rbu_pkg::NBLK-1:0]     rem_next;
  logic [1:0]                   smax;
  logic                         last_dx;
  logic                         blk_end;
  logic                         emit;
  logic                         step;
  logic                         done;
  logic                         load;
  logic [rbu_pkg::POS_W-1:0]    c12;
  logic [rbu_pkg::POS_W-1:0]    r12;
  logic [rbu_pkg::POS_W-1:0]    bc;
  logic [rbu_pkg::POS_W-1:0]    br;
  logic [rbu_pkg::POS_W-1:0]    bc_s;
  logic [rbu_pkg::POS_W-1:0]    br_s;

  assign blk_oh   = rem_q & (~rem_q + rbu_pkg::NBLK'(1));
  assign rem_next = rem_q & ~blk_oh;
  assign smax     = w_q.s3 ? 2'd2 : 2'd3;
  assign last_dx  = (dx_q == smax);
  assign blk_end  = last_dx && (dy_q == smax);
  assign emit     = w_valid_q && (rem_q != '0);
  assign step     = emit && en_i;
  assign done     = w_valid_q && ((rem_q == '0) || (step && blk_end && (rem_next == '0)));
  assign a_take_o = !w_valid_q || done;
  assign load     = a_valid_i && a_take_o;

  assign c12 = rbu_pkg::POS_W'(w_q.c);
  assign r12 = rbu_pkg::POS_W'(w_q.r);

  always_comb begin
    case (blk_oh)
      4'b0001: begin
        gen_o.ul = w_ul_q;
        gen_o.ur = w_above_q;
        gen_o.ll = w_q.left;
        gen_o.lr = w_q.cur;
        bc       = c12 - rbu_pkg::POS_W'(1);
        br       = r12 - rbu_pkg::POS_W'(1);
      end
      4'b0010: begin
        gen_o.ul = w_above_q;
        gen_o.ur = w_above_q;
        gen_o.ll = w_q.cur;
        gen_o.lr = w_q.cur;
        bc       = c12;
        br       = r12 - rbu_pkg::POS_W'(1);
      end
      4'b0100: begin
        gen_o.ul = w_q.left;
        gen_o.ur = w_q.cur;
        gen_o.ll = w_q.left;
        gen_o.lr = w_q.cur;
        bc       = c12 - rbu_pkg::POS_W'(1);
        br       = r12;
      end
      default: begin
        gen_o.ul = w_q.cur;
        gen_o.ur = w_q.cur;
        gen_o.ll = w_q.cur;
        gen_o.lr = w_q.cur;
        bc       = c12;
        br       = r12;
      end
    endcase
    bc_s = w_q.s3 ? rbu_pkg::POS_W'({bc, 1'b0}) + bc : rbu_pkg::POS_W'({bc, 2'b00});
    br_s = w_q.s3 ? rbu_pkg::POS_W'({br, 1'b0}) + br : rbu_pkg::POS_W'({br, 2'b00});
    gen_o.col       = bc_s + rbu_pkg::POS_W'(dx_q);
    gen_o.row       = br_s + rbu_pkg::POS_W'(dy_q);
    gen_o.wt        = rbu_pkg::weights(w_q.s3, dy_q, dx_q);
    gen_o.last_run  = blk_end && (rem_next == '0);
    gen_o.frame_end = blk_end && (rem_next == '0) && w_q.lastr && w_q.lastc;
  end

  assign gen_valid_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      ul_q      <= '0;
      rem_q     <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
    end else if (load) begin
      w_valid_q <= 1'b1;
      ul_q      <= above_i;
      rem_q     <= a_item_i.mask;
      dx_q      <= '0;
      dy_q      <= '0;
    end else if (done) begin
      w_valid_q <= 1'b0;
      rem_q     <= '0;
      dx_q      <= '0;
      dy_q      <= '0;
    end else if (step) begin
      if (last_dx) begin
        dx_q <= '0;
        if (blk_end) begin
          dy_q  <= '0;
          rem_q <= rem_next;
        end else begin
          dy_q <= dy_q + 2'd1;
        end
      end else begin
        dx_q <= dx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      w_q       <= a_item_i;
      w_above_q <= above_i;
      w_ul_q    <= ul_q;
    end
  end

endmodule

### src/rbu_interp.sv
module rbu_interp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          gen_valid_i,
  input  rbu_pkg::gen_t gen_i,
  output logic          en_o,
  rbu_res_if.source     res_o
);

  logic                         s1_valid_q;
  logic [rbu_pkg::PROD_W-1:0]   prod_q [3][4];
  logic [rbu_pkg::PROD_W-1:0]   prod_d [3][4];
  logic [3:0]                   sh_q;
  logic [rbu_pkg::POS_W-1:0]    s1_col_q;
  logic [rbu_pkg::POS_W-1:0]    s1_row_q;
  logic                         s1_last_q;
  logic                         s1_fd_q;

  logic                         out_valid_q;
  logic [rbu_pkg::CH_W-1:0]     ch_q [3];
  logic [rbu_pkg::CH_W-1:0]     ch_d [3];
  logic [rbu_pkg::POS_W-1:0]    col_q;
  logic [rbu_pkg::POS_W-1:0]    row_q;
  logic                         last_q;
  logic                         fd_q;
  logic [rbu_pkg::SUM_W-1:0]    sum;

  assign en_o = !out_valid_q || res_o.ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_d[k][0] = rbu_pkg::PROD_W'(rbu_pkg::chan(gen_i.ul, k)) * rbu_pkg::PROD_W'(gen_i.wt.w0);
      prod_d[k][1] = rbu_pkg::PROD_W'(rbu_pkg::chan(gen_i.ur, k)) * rbu_pkg::PROD_W'(gen_i.wt.w1);
      prod_d[k][2] = rbu_pkg::PROD_W'(rbu_pkg::chan(gen_i.ll, k)) * rbu_pkg::PROD_W'(gen_i.wt.w2);
      prod_d[k][3] = rbu_pkg::PROD_W'(rbu_pkg::chan(gen_i.lr, k)) * rbu_pkg::PROD_W'(gen_i.wt.w3);
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sum = rbu_pkg::SUM_W'(prod_q[k][0]) + rbu_pkg::SUM_W'(prod_q[k][1])
          + rbu_pkg::SUM_W'(prod_q[k][2]) + rbu_pkg::SUM_W'(prod_q[k][3]);
      ch_d[k] = rbu_pkg::CH_W'(sum >> sh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      s1_valid_q  <= gen_valid_i;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      prod_q    <= prod_d;
      sh_q      <= gen_i.wt.sh;
      s1_col_q  <= gen_i.col;
      s1_row_q  <= gen_i.row;
      s1_last_q <= gen_i.last_run;
      s1_fd_q   <= gen_i.frame_end;
      ch_q      <= ch_d;
      col_q     <= s1_col_q;
      row_q     <= s1_row_q;
      last_q    <= s1_last_q;
      fd_q      <= s1_fd_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.red_out     = ch_q[0];
  assign res_o.green_out   = ch_q[1];
  assign res_o.blue_out    = ch_q[2];
  assign res_o.out_col     = col_q;
  assign res_o.out_row     = row_q;
  assign res_o.last_of_run = last_q;
  assign res_o.frame_done  = fd_q;

endmodule

### src/rgb_bilinear_upscale_2d.sv
// RGB bilinear upscaler, factor 3 or 4 on both axes.
// pix_i takes input pixels in raster order; res_o returns output pixels with
// their output column and row, last_of_run on the last pixel caused by an
// input item and frame_done on the final pixel of the frame.
// Registers (cfg_we_i/cfg_idx_i/cfg_data_i): 0 scale factor, 1 width, 2 height;
// write them only while the block is idle.
// Path: an accepted item waits in the staging register and is loaded into the
// emitter; each result then passes the product and output registers.
// Throughput: the emitter produces one output pixel per cycle unless the output
// pipeline holds, and takes the next item with its last result; an item has 0,
// 9 or 16 results typically, up to 64 at the frame edges; top-row items pass at
// one per cycle. The line memory does one read and one write per accepted item.
// Reset clears the counters and the neighbor pixels, sets factor 4 and a
// 1024x1024 frame; the line memory is not cleared and is valid once the first
// row has been written.
// When res_o.ready is low with a result waiting the output pipeline holds;
// pix_i.ready falls once the staging register and the emitter are both occupied.
module rgb_bilinear_upscale_2d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rbu_pkg::CFG_W-1:0]     cfg_data_i,
  rbu_pix_if.sink                       pix_i,
  rbu_res_if.source                     res_o
);

  logic                      a_valid;
  rbu_pkg::item_t            a_item;
  logic [rbu_pkg::PIX_W-1:0] above;
  logic                      a_take;
  logic                      gen_valid;
  rbu_pkg::gen_t             gen;
  logic                      en;

  rbu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .a_valid_o  (a_valid),
    .a_item_o   (a_item),
    .above_o    (above),
    .a_take_i   (a_take)
  );

  rbu_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .a_valid_i   (a_valid),
    .a_item_i    (a_item),
    .above_i     (above),
    .a_take_o    (a_take),
    .en_i        (en),
    .gen_valid_o (gen_valid),
    .gen_o       (gen)
  );

  rbu_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gen_valid_i (gen_valid),
    .gen_i       (gen),
    .en_o        (en),
    .res_o       (res_o)
  );

endmodule

### src/rbu_chk.sv
module rbu_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rbu_pkg::CH_W-1:0]  red_i,
  input logic [rbu_pkg::CH_W-1:0]  green_i,
  input logic [rbu_pkg::CH_W-1:0]  blue_i,
  input logic [rbu_pkg::POS_W-1:0] col_i,
  input logic [rbu_pkg::POS_W-1:0] row_i,
  input logic                      last_i,
  input logic                      done_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({red_i, green_i, blue_i, col_i, row_i, last_i, done_i}))
    else $error("output item changed while stalled");

  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> last_i)
    else $error("frame end not on last item of a run");

  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("gap inside a run");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind rgb_bilinear_upscale_2d rbu_chk u_rbu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .red_i       (res_o.red_out),
  .green_i     (res_o.green_out),
  .blue_i      (res_o.blue_out),
  .col_i       (res_o.out_col),
  .row_i       (res_o.out_row),
  .last_i      (res_o.last_of_run),
  .done_i      (res_o.frame_done)
);
